FILE: rtl/esu8_pkg.sv
package esu8_pkg;

  // escape mode of the front end
  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_BSL,
    MODE_OCT,
    MODE_HEX
  } mode_e;

  // kind of work handed from front to back
  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_END,
    CMD_CODE
  } cmd_kind_e;

  // one queued command
  typedef struct packed {
    cmd_kind_e   kind;
    logic [31:0] code;
    logic [7:0]  data;
    logic        tail;
  } cmd_t;

  // character codes
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharSeven = 8'h37;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowF  = 8'h66;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;
  localparam logic [7:0] CharU     = 8'h75;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharBsl   = 8'h5C;
  localparam logic [7:0] CharQuote = 8'h22;

  // hex letter digit offset
  localparam logic [3:0] HexLetterOfs = 4'd9;

endpackage

FILE: rtl/esu8_front.sv
module esu8_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  output logic              cmd_valid_o,
  output esu8_pkg::cmd_t    cmd_o,
  input  logic              cmd_ready_i
);
  import esu8_pkg::*;

  mode_e       mode_q, mode_d;
  logic [31:0] acc_q, acc_d;
  logic        fire;
  logic        is_term, is_oct, is_dec, is_hexa;
  logic [3:0]  hex_digit;

  assign in_ready_o = cmd_ready_i;
  assign fire       = in_valid_i & cmd_ready_i;

  // byte classification
  assign is_term   = (in_byte_i == CharNul);
  assign is_oct    = (in_byte_i >= CharZero) && (in_byte_i <= CharSeven);
  assign is_dec    = (in_byte_i >= CharZero) && (in_byte_i <= CharNine);
  assign is_hexa   = ((in_byte_i >= CharLowA) && (in_byte_i <= CharLowF)) ||
                     ((in_byte_i >= CharUpA) && (in_byte_i <= CharUpF));
  assign hex_digit = is_dec ? in_byte_i[3:0] : in_byte_i[3:0] + HexLetterOfs;

  // next escape mode
  always_comb begin
    mode_d = mode_q;
    if (fire) begin
      if (is_term) begin
        mode_d = MODE_NONE;
      end else begin
        case (mode_q)
          MODE_OCT: if (!is_oct) mode_d = MODE_NONE;
          MODE_HEX: if (!(is_dec || is_hexa)) mode_d = MODE_NONE;
          MODE_BSL: begin
            if (in_byte_i == CharZero)   mode_d = MODE_OCT;
            else if (in_byte_i == CharU) mode_d = MODE_HEX;
            else                         mode_d = MODE_NONE;
          end
          default: if (in_byte_i == CharBsl) mode_d = MODE_BSL;
        endcase
      end
    end
  end

  // code accumulator and command output
  always_comb begin
    acc_d       = acc_q;
    cmd_valid_o = 1'b0;
    cmd_o.kind  = CMD_BYTE;
    cmd_o.code  = acc_q;
    cmd_o.data  = in_byte_i;
    cmd_o.tail  = (in_byte_i != CharDot);
    if (is_term) begin
      cmd_valid_o = in_valid_i;
      cmd_o.kind  = CMD_END;
      acc_d       = fire ? 32'd0 : acc_q;
    end else begin
      case (mode_q)
        MODE_OCT: begin
          if (is_oct) begin
            if (fire) acc_d = {acc_q[28:0], in_byte_i[2:0]};
          end else begin
            cmd_valid_o = in_valid_i;
            cmd_o.kind  = CMD_CODE;
          end
        end
        MODE_HEX: begin
          if (is_dec || is_hexa) begin
            if (fire) acc_d = {acc_q[27:0], hex_digit};
          end else begin
            cmd_valid_o = in_valid_i;
            cmd_o.kind  = CMD_CODE;
          end
        end
        MODE_BSL: begin
          if (fire) acc_d = 32'd0;
          cmd_valid_o = in_valid_i && (in_byte_i != CharZero) && (in_byte_i != CharU);
        end
        default: begin
          cmd_valid_o = in_valid_i && (in_byte_i != CharBsl) && (in_byte_i != CharQuote);
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NONE;
      acc_q  <= 32'd0;
    end else begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
    end
  end

endmodule

FILE: rtl/esu8_cmdq.sv
module esu8_cmdq #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  esu8_pkg::cmd_t    push_cmd_i,
  output logic              head_valid_o,
  output esu8_pkg::cmd_t    head_cmd_o,
  input  logic              pop_i
);
  import esu8_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign head_valid_o = (cnt_q != '0);
  assign head_cmd_o   = slots_q[rd_ptr_q];
  assign do_push      = push_valid_i & push_ready_o;
  assign do_pop       = pop_i & head_valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    if (do_push && !do_pop)      cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

FILE: rtl/esu8_back.sv
module esu8_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  esu8_pkg::cmd_t    cmd_i,
  output logic              cmd_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [7:0]        out_byte_o,
  output logic              run_last_o,
  output logic              string_end_o,
  output logic              code_error_o
);
  import esu8_pkg::*;

  logic [2:0]  idx_q, idx_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q;
  logic        out_last_q, out_end_q, out_err_q;

  logic        cp_zero, cp_err;
  logic [2:0]  enc_n, total, lvl;
  logic [7:0]  lead;
  logic [4:0]  sh;
  logic [31:0] shifted;
  logic [7:0]  enc_byte;

  logic [7:0]  beat_byte;
  logic        beat_last, beat_end, beat_err, beat_go;

  // utf-8 length and lead byte of the code point
  always_comb begin
    cp_zero = (cmd_i.code == 32'd0);
    cp_err  = cmd_i.code[31];
    enc_n   = 3'd1;
    lead    = 8'h00;
    if (cp_zero) begin
      enc_n = 3'd2;
    end else if (cp_err || cmd_i.code < 32'h80) begin
      enc_n = 3'd1;
    end else if (cmd_i.code < 32'h800) begin
      enc_n = 3'd2; lead = 8'hC0;
    end else if (cmd_i.code < 32'h1_0000) begin
      enc_n = 3'd3; lead = 8'hE0;
    end else if (cmd_i.code < 32'h20_0000) begin
      enc_n = 3'd4; lead = 8'hF0;
    end else if (cmd_i.code < 32'h400_0000) begin
      enc_n = 3'd5; lead = 8'hF8;
    end else begin
      enc_n = 3'd6; lead = 8'hFC;
    end
  end

  // encoded byte at the current beat index
  assign total   = enc_n + {2'b00, cmd_i.tail};
  assign lvl     = enc_n - 3'd1 - idx_q;
  assign sh      = 5'({2'b00, lvl} * 5'd6);
  assign shifted = cmd_i.code >> sh;

  always_comb begin
    if (cp_zero)          enc_byte = (idx_q == 3'd0) ? 8'hC0 : 8'h80;
    else if (cp_err)      enc_byte = 8'h00;
    else if (idx_q == 3'd0) enc_byte = lead | shifted[7:0];
    else                  enc_byte = 8'h80 | {2'b00, shifted[5:0]};
  end

  // beat selection per command kind
  always_comb begin
    beat_byte = cmd_i.data;
    beat_last = 1'b1;
    beat_end  = 1'b0;
    beat_err  = 1'b0;
    case (cmd_i.kind)
      CMD_END: begin
        beat_byte = 8'h00;
        beat_end  = 1'b1;
      end
      CMD_CODE: begin
        beat_last = (idx_q == total - 3'd1);
        if (idx_q < enc_n) begin
          beat_byte = enc_byte;
          beat_err  = cp_err;
        end
      end
      default: begin
        beat_byte = cmd_i.data;
      end
    endcase
  end

  // sequencing of beats and output register load
  assign beat_go   = cmd_valid_i & (!out_valid_q | pop_i);
  assign cmd_pop_o = beat_go & beat_last;
  assign idx_d     = beat_go ? (beat_last ? 3'd0 : idx_q + 3'd1) : idx_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (beat_go)    out_valid_d = 1'b1;
    else if (pop_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (beat_go) begin
      out_byte_q <= beat_byte;
      out_last_q <= beat_last;
      out_end_q  <= beat_end;
      out_err_q  <= beat_err;
    end
  end

  assign empty_o      = !out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign run_last_o   = out_last_q;
  assign string_end_o = out_end_q;
  assign code_error_o = out_err_q;

endmodule

FILE: rtl/escaped_string_to_utf8.sv
// escaped string decoder with utf-8 output
//
// input channel: one string byte per beat on in_byte_i, taken when push is
// high and full is low. a zero byte ends the string.
// result channel: decoded bytes leave on out_byte_o with run_last_o,
// string_end_o and code_error_o while empty is low; a beat is taken when
// pop is high. run_last_o marks the last result beat of one input byte.
// a byte's command is queued before its first result beat is registered.
// throughput: one input byte per cycle and one result beat per cycle while
// pop is high. a byte that ends a numeric escape makes up to seven result
// beats, issued one per cycle by the back-end sequencer; the command queue
// between the front end and the sequencer (QueueDepth entries) absorbs the
// burst while input keeps flowing until the queue fills and full rises.
// reset: escape mode none, code accumulator zero, queue and output empty.
// receiver stall: the output register holds its beat, the sequencer waits,
// the queue fills and full rises; nothing is lost or repeated.
module escaped_string_to_utf8 #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       string_end_o,
  output logic       code_error_o
);
  import esu8_pkg::*;

  logic in_ready;
  logic fc_valid, fc_ready;
  cmd_t fc_cmd;
  logic hd_valid, hd_pop;
  cmd_t hd_cmd;

  assign full = !in_ready;

  // front end: escape tracking and classification
  esu8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push),
    .in_ready_o  (in_ready),
    .in_byte_i   (in_byte_i),
    .cmd_valid_o (fc_valid),
    .cmd_o       (fc_cmd),
    .cmd_ready_i (fc_ready)
  );

  // command queue
  esu8_cmdq #(
    .Depth (QueueDepth)
  ) u_cmdq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fc_valid),
    .push_ready_o (fc_ready),
    .push_cmd_i   (fc_cmd),
    .head_valid_o (hd_valid),
    .head_cmd_o   (hd_cmd),
    .pop_i        (hd_pop)
  );

  // back end: beat sequencer and output register
  esu8_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (hd_valid),
    .cmd_i        (hd_cmd),
    .cmd_pop_o    (hd_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o),
    .code_error_o (code_error_o)
  );

endmodule
